FILE: src/gim_pkg.sv
package gim_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int DEF_COORD_BITS = 10;
   localparam int FLAT_W         = 40;
   // quotient bits resolved per divider stage
   localparam int DIV_STEPS      = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int ND_W           = $clog2(MAX_DIMS + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_DIMS = 3'd0,
      CSR_EXTENT_0 = 3'd1,
      CSR_EXTENT_1 = 3'd2,
      CSR_EXTENT_2 = 3'd3,
      CSR_EXTENT_3 = 3'd4
   } csr_index_type;

   localparam logic OP_TO_FLAT  = 1'b0;
   localparam logic OP_TO_COORD = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [FLAT_W-1:0] dividend;
      logic [FLAT_W-1:0] acc;
   } lane_bus_type;

endpackage

FILE: src/gim_lane.sv
module gim_lane #(
   parameter int COORD_BITS = gim_pkg::DEF_COORD_BITS,
   parameter int SIDE_W     = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gim_pkg::lane_bus_type     lane_in,
   input  logic [SIDE_W-1:0]         side_in,
   input  logic [COORD_BITS:0]       div_extent,
   input  logic [COORD_BITS:0]       mac_extent,
   input  logic [COORD_BITS-1:0]     mac_coord,
   output gim_pkg::lane_bus_type     lane_out,
   output logic [COORD_BITS-1:0]     rem_out,
   output logic [SIDE_W-1:0]         side_out
);
   import gim_pkg::*;

   localparam int EXT_W  = COORD_BITS + 1;
   localparam int STAGES = (FLAT_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W  = STAGES * DIV_STEPS;

   logic                  valid_ff [STAGES];
   logic                  valid_in [STAGES];
   logic [DIV_W-1:0]      dv_ff    [STAGES];
   logic [DIV_W-1:0]      dv_in    [STAGES];
   logic [COORD_BITS-1:0] rem_ff   [STAGES];
   logic [COORD_BITS-1:0] rem_in   [STAGES];
   logic [FLAT_W-1:0]     acc_ff   [STAGES];
   logic [FLAT_W-1:0]     acc_in   [STAGES];
   logic [SIDE_W-1:0]     side_ff  [STAGES];
   logic [SIDE_W-1:0]     side_in_s[STAGES];

   // restoring division, DIV_STEPS quotient bits a stage; Horner step in stage 0
   always_comb begin
      logic [DIV_W-1:0]        dv;
      logic [COORD_BITS-1:0]   rm;
      logic [COORD_BITS:0]     r2;
      logic [FLAT_W+EXT_W-1:0] prod;
      prod = lane_in.acc * mac_extent;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            dv           = DIV_W'(lane_in.dividend);
            rm           = '0;
            valid_in[s]  = lane_in.valid;
            side_in_s[s] = side_in;
            acc_in[s]    = prod[FLAT_W-1:0] + FLAT_W'(mac_coord);
         end else begin
            dv           = dv_ff[s-1];
            rm           = rem_ff[s-1];
            valid_in[s]  = valid_ff[s-1];
            side_in_s[s] = side_ff[s-1];
            acc_in[s]    = acc_ff[s-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            r2 = {rm, dv[DIV_W-1]};
            dv = {dv[DIV_W-2:0], 1'b0};
            if (r2 >= div_extent) begin
               rm    = COORD_BITS'(r2 - div_extent);
               dv[0] = 1'b1;
            end else begin
               rm = r2[COORD_BITS-1:0];
            end
         end
         dv_in[s]  = dv;
         rem_in[s] = rm;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         dv_ff[s]   <= dv_in[s];
         rem_ff[s]  <= rem_in[s];
         acc_ff[s]  <= acc_in[s];
         side_ff[s] <= side_in_s[s];
      end
   end

   assign lane_out.valid    = valid_ff[STAGES-1];
   assign lane_out.dividend = dv_ff[STAGES-1][FLAT_W-1:0];
   assign lane_out.acc      = acc_ff[STAGES-1];
   assign rem_out           = rem_ff[STAGES-1];
   assign side_out          = side_ff[STAGES-1];

endmodule

FILE: src/gim_merge.sv
module gim_merge #(
   parameter int COORD_BITS = gim_pkg::DEF_COORD_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [gim_pkg::ND_W-1:0]                   nd,
   input  gim_pkg::lane_bus_type                      lane_in,
   input  logic                                       op,
   input  logic                                       oor0,
   input  logic [COORD_BITS-1:0]                      fsat,
   input  logic [gim_pkg::MAX_DIMS*COORD_BITS-1:0]    rems,
   input  logic [gim_pkg::MAX_DIMS*COORD_BITS-1:0]    qsats,
   input  logic [gim_pkg::MAX_DIMS-1:0]               qnz,
   output logic                                       rsp_valid,
   output logic [gim_pkg::FLAT_W-1:0]                 flat_out,
   output logic [gim_pkg::MAX_DIMS*COORD_BITS-1:0]    coords,
   output logic                                       oor
);
   import gim_pkg::*;

   logic                             valid_ff;
   logic [FLAT_W-1:0]                flat_ff, flat_in;
   logic [MAX_DIMS*COORD_BITS-1:0]   crd_ff, crd_in;
   logic                             oor_ff, oor_in;
   logic [COORD_BITS-1:0]            top_val [MAX_DIMS];
   logic [ND_W-1:0]                  top;
   logic                             oor1;

   always_comb begin
      top        = nd - ND_W'(1);
      top_val[0] = fsat;
      for (int i = 1; i < MAX_DIMS; i++) begin
         top_val[i] = qsats[(i-1)*COORD_BITS +: COORD_BITS];
      end
      oor1   = 1'b0;
      crd_in = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (ND_W'(i) == top) begin
            oor1 = qnz[i];
            crd_in[i*COORD_BITS +: COORD_BITS] = top_val[i];
         end else if (ND_W'(i) < top) begin
            crd_in[i*COORD_BITS +: COORD_BITS] = rems[i*COORD_BITS +: COORD_BITS];
         end
      end
      if (op == OP_TO_FLAT) begin
         crd_in  = '0;
         flat_in = lane_in.acc;
         oor_in  = oor0;
      end else begin
         flat_in = '0;
         oor_in  = oor1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      flat_ff <= flat_in;
      crd_ff  <= crd_in;
      oor_ff  <= oor_in;
   end

   assign rsp_valid = valid_ff;
   assign flat_out  = flat_ff;
   assign coords    = crd_ff;
   assign oor       = oor_ff;

endmodule

FILE: src/grid_index_mapper_unit.sv
// Path from start to rsp_valid: the entry register, the four divider lanes of ten stages
//   each (four quotient bits a stage), then the merge register.
// Throughput: one beat a cycle; busy never rises and the result strobe cannot be held off.
// Reset (synchronous, active high) empties the pipeline and restores num_dims to 1 and
//   every extent to its maximum; csr_ready stays high.
module grid_index_mapper_unit #(
   parameter int COORD_BITS = gim_pkg::DEF_COORD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [COORD_BITS-1:0]           req_coord_in_0,
   input  logic [COORD_BITS-1:0]           req_coord_in_1,
   input  logic [COORD_BITS-1:0]           req_coord_in_2,
   input  logic [COORD_BITS-1:0]           req_coord_in_3,
   input  logic [gim_pkg::FLAT_W-1:0]      req_flat_in,
   // result channel
   output logic                            rsp_valid,
   output logic [gim_pkg::FLAT_W-1:0]      rsp_flat_out,
   output logic [COORD_BITS-1:0]           rsp_coord_out_0,
   output logic [COORD_BITS-1:0]           rsp_coord_out_1,
   output logic [COORD_BITS-1:0]           rsp_coord_out_2,
   output logic [COORD_BITS-1:0]           rsp_coord_out_3,
   output logic                            rsp_out_of_range,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gim_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_BITS:0]             csr_wdata
);
   import gim_pkg::*;

   localparam int EXT_W = COORD_BITS + 1;
   localparam int CMP_W = (EXT_W > 3) ? EXT_W : 3;
   localparam int CB    = COORD_BITS;
   localparam logic [CB-1:0]    COORD_MAX  = '1;
   localparam logic [EXT_W-1:0] EXTENT_CAP = EXT_W'(1) << COORD_BITS;

   // sideband carried alongside the lanes
   localparam int OFS_OP   = 0;
   localparam int OFS_OOR  = 1;
   localparam int OFS_FSAT = 2;
   localparam int OFS_CRD  = OFS_FSAT + CB;
   localparam int OFS_REM  = OFS_CRD + MAX_DIMS * CB;
   localparam int OFS_QS   = OFS_REM + MAX_DIMS * CB;
   localparam int OFS_QNZ  = OFS_QS + MAX_DIMS * CB;
   localparam int SIDE_W   = OFS_QNZ + MAX_DIMS;

   // ---------------- configuration registers ----------------
   // Values are stored already clamped: dimension count to 1..MAX_DIMS,
   // extents to 1..2^COORD_BITS.
   logic [ND_W-1:0]  nd_ff, nd_in;
   logic [EXT_W-1:0] ext_ff [MAX_DIMS];
   logic [EXT_W-1:0] ext_in [MAX_DIMS];
   logic [2:0]       nd_raw;
   logic [CMP_W-1:0] ext_raw;
   logic [EXT_W-1:0] ext_eff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      ext_raw = CMP_W'(csr_wdata);
      nd_raw  = ext_raw[2:0];
      if (ext_raw == '0) begin
         ext_eff = EXT_W'(1);
      end else if (ext_raw > CMP_W'(EXTENT_CAP)) begin
         ext_eff = EXTENT_CAP;
      end else begin
         ext_eff = ext_raw[EXT_W-1:0];
      end
      nd_in = nd_ff;
      for (int i = 0; i < MAX_DIMS; i++) begin
         ext_in[i] = ext_ff[i];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_DIMS: begin
               if (nd_raw == '0) begin
                  nd_in = ND_W'(1);
               end else if (4'(nd_raw) > 4'(MAX_DIMS)) begin
                  nd_in = ND_W'(MAX_DIMS);
               end else begin
                  nd_in = ND_W'(nd_raw);
               end
            end
            CSR_EXTENT_0: ext_in[0] = ext_eff;
            CSR_EXTENT_1: ext_in[1] = ext_eff;
            CSR_EXTENT_2: ext_in[2] = ext_eff;
            CSR_EXTENT_3: ext_in[3] = ext_eff;
            default: ; // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff <= ND_W'(1);
         for (int i = 0; i < MAX_DIMS; i++) begin
            ext_ff[i] <= EXTENT_CAP;
         end
      end else begin
         nd_ff <= nd_in;
         for (int i = 0; i < MAX_DIMS; i++) begin
            ext_ff[i] <= ext_in[i];
         end
      end
   end

   // ---------------- entry stage ----------------
   // Unused coordinates are zeroed here, so the Horner chain over all lanes
   // sees them as zero. The coordinate bound check is done once, up front.
   logic [CB-1:0]     crd     [MAX_DIMS];
   logic              ent_valid_ff;
   logic [FLAT_W-1:0] ent_flat_ff;
   logic [SIDE_W-1:0] ent_side_ff, ent_side_in;
   logic              oor0;

   always_comb begin
      crd[0] = req_coord_in_0;
      crd[1] = req_coord_in_1;
      crd[2] = req_coord_in_2;
      crd[3] = req_coord_in_3;
      oor0   = 1'b0;
      ent_side_in = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (ND_W'(i) < nd_ff) begin
            ent_side_in[OFS_CRD + i*CB +: CB] = crd[i];
            if (EXT_W'(crd[i]) >= ext_ff[i]) begin
               oor0 = 1'b1;
            end
         end
      end
      ent_side_in[OFS_OP]  = req_operation;
      ent_side_in[OFS_OOR] = oor0;
      ent_side_in[OFS_FSAT +: CB] = (req_flat_in > FLAT_W'(COORD_MAX)) ?
                                    COORD_MAX : req_flat_in[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      ent_flat_ff <= req_flat_in;
      ent_side_ff <= ent_side_in;
   end

   // ---------------- lanes ----------------
   // Lane k divides by extent k (quotient feeds lane k+1, remainder is
   // coordinate k) and performs one Horner step for dimension MAX_DIMS-1-k.
   lane_bus_type      bus_at  [MAX_DIMS+1];
   logic [SIDE_W-1:0] side_at [MAX_DIMS+1];

   always_comb begin
      bus_at[0].valid    = ent_valid_ff;
      bus_at[0].dividend = ent_flat_ff;
      bus_at[0].acc      = '0;
      side_at[0]         = ent_side_ff;
   end

   for (genvar k = 0; k < MAX_DIMS; k++) begin : g_lane
      lane_bus_type      lbus;
      logic [SIDE_W-1:0] lside;
      logic [CB-1:0]     lrem;

      gim_lane #(
         .COORD_BITS (COORD_BITS),
         .SIDE_W     (SIDE_W)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_in    (bus_at[k]),
         .side_in    (side_at[k]),
         .div_extent (ext_ff[k]),
         .mac_extent (ext_ff[MAX_DIMS-1-k]),
         .mac_coord  (side_at[k][OFS_CRD + (MAX_DIMS-1-k)*CB +: CB]),
         .lane_out   (lbus),
         .rem_out    (lrem),
         .side_out   (lside)
      );

      always_comb begin
         bus_at[k+1]  = lbus;
         side_at[k+1] = lside;
         side_at[k+1][OFS_REM + k*CB +: CB] = lrem;
         side_at[k+1][OFS_QS + k*CB +: CB]  = (lbus.dividend > FLAT_W'(COORD_MAX)) ?
                                              COORD_MAX : lbus.dividend[CB-1:0];
         side_at[k+1][OFS_QNZ + k]          = |lbus.dividend;
      end
   end

   // ---------------- merge ----------------
   logic [MAX_DIMS*CB-1:0] coords;

   gim_merge #(
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .nd        (nd_ff),
      .lane_in   (bus_at[MAX_DIMS]),
      .op        (side_at[MAX_DIMS][OFS_OP]),
      .oor0      (side_at[MAX_DIMS][OFS_OOR]),
      .fsat      (side_at[MAX_DIMS][OFS_FSAT +: CB]),
      .rems      (side_at[MAX_DIMS][OFS_REM +: MAX_DIMS*CB]),
      .qsats     (side_at[MAX_DIMS][OFS_QS +: MAX_DIMS*CB]),
      .qnz       (side_at[MAX_DIMS][OFS_QNZ +: MAX_DIMS]),
      .rsp_valid (rsp_valid),
      .flat_out  (rsp_flat_out),
      .coords    (coords),
      .oor       (rsp_out_of_range)
   );

   assign rsp_coord_out_0 = coords[0*CB +: CB];
   assign rsp_coord_out_1 = coords[1*CB +: CB];
   assign rsp_coord_out_2 = coords[2*CB +: CB];
   assign rsp_coord_out_3 = coords[3*CB +: CB];

endmodule

FILE: bench/tb_grid_index_mapper_unit.sv
module tb_grid_index_mapper_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import gim_pkg::*;

   localparam int CB      = DEF_COORD_BITS;
   localparam int LATENCY = 42;

   typedef struct {
      logic              op;
      logic [CB-1:0]     coord[MAX_DIMS];
      logic [FLAT_W-1:0] flat;
   } cmd_beat_type;

   typedef struct {
      logic [FLAT_W-1:0] flat;
      logic [CB-1:0]     coord[MAX_DIMS];
      logic              oor;
   } map_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [CB-1:0] req_coord_in_0 = '0, req_coord_in_1 = '0;
   logic [CB-1:0] req_coord_in_2 = '0, req_coord_in_3 = '0;
   logic [FLAT_W-1:0] req_flat_in = '0;
   logic rsp_valid;
   logic [FLAT_W-1:0] rsp_flat_out;
   logic [CB-1:0] rsp_coord_out_0, rsp_coord_out_1, rsp_coord_out_2, rsp_coord_out_3;
   logic rsp_out_of_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CB:0] csr_wdata = '0;

   grid_index_mapper_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the shape registers, raw as written
   logic [2:0]  shadow_dims;
   logic [CB:0] shadow_extent[MAX_DIMS];

   cmd_beat_type   pending_beats[$];
   map_result_type expected_maps[$];
   int             mismatch_count = 0;
   int             idle_left = 0;
   bit             idle_enabled = 1'b1;
   bit             hold_off = 1'b0;

   function automatic int active_dims();
      if (shadow_dims == 0) return 1;
      if (shadow_dims > MAX_DIMS) return MAX_DIMS;
      return shadow_dims;
   endfunction

   function automatic longint unsigned dim_size(int i);
      if (shadow_extent[i] == 0) return 1;
      if (shadow_extent[i] > 1024) return 1024;
      return shadow_extent[i];
   endfunction

   // column-major linearisation / delinearisation
   function automatic map_result_type map_grid(cmd_beat_type b);
      map_result_type r;
      longint unsigned stride[MAX_DIMS];
      longint unsigned span, rest, q;
      int nd;
      nd = active_dims();
      span = 1;
      for (int i = 0; i < MAX_DIMS; i++) begin
         stride[i] = span;
         r.coord[i] = '0;
         if (i < nd) span *= dim_size(i);
      end
      r.oor = 1'b0;
      r.flat = '0;
      if (b.op == OP_TO_FLAT) begin
         rest = 0;
         for (int i = 0; i < nd; i++) begin
            if (b.coord[i] >= dim_size(i)) r.oor = 1'b1;
            rest += longint'(b.coord[i]) * stride[i];
         end
         r.flat = rest[FLAT_W-1:0];
      end else begin
         rest = b.flat;
         if (rest >= span) r.oor = 1'b1;
         for (int i = nd - 1; i >= 0; i--) begin
            q = rest / stride[i];
            rest = rest % stride[i];
            if (q > 1023) q = 1023;
            r.coord[i] = q[CB-1:0];
         end
      end
      return r;
   endfunction

   // driver: one beat per accepted start, bursts of idle cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_maps.push_back(map_grid(pending_beats.pop_front()));
         end
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
            idle_left <= $urandom_range(0, 7);
            start <= 1'b0;
         end else if (!hold_off && pending_beats.size() > 0) begin
            start          <= 1'b1;
            req_operation  <= pending_beats[0].op;
            req_coord_in_0 <= pending_beats[0].coord[0];
            req_coord_in_1 <= pending_beats[0].coord[1];
            req_coord_in_2 <= pending_beats[0].coord[2];
            req_coord_in_3 <= pending_beats[0].coord[3];
            req_flat_in    <= pending_beats[0].flat;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is checked against the oldest expectation
   always @(posedge clock) begin
      map_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_maps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat");
         end else begin
            exp_r = expected_maps.pop_front();
            if (rsp_flat_out !== exp_r.flat || rsp_coord_out_0 !== exp_r.coord[0] ||
                rsp_coord_out_1 !== exp_r.coord[1] || rsp_coord_out_2 !== exp_r.coord[2] ||
                rsp_coord_out_3 !== exp_r.coord[3] || rsp_out_of_range !== exp_r.oor) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp flat=%0d c=%0d,%0d,%0d,%0d oor=%0b",
                     exp_r.flat, exp_r.coord[0], exp_r.coord[1], exp_r.coord[2],
                     exp_r.coord[3], exp_r.oor,
                     " got flat=%0d c=%0d,%0d,%0d,%0d oor=%0b",
                     rsp_flat_out, rsp_coord_out_0, rsp_coord_out_1,
                     rsp_coord_out_2, rsp_coord_out_3, rsp_out_of_range);
            end
         end
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [CB:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_NUM_DIMS) shadow_dims = value[2:0];
      else shadow_extent[idx - 1] = value;
   endtask

   // wait for every expectation, then let the pipe drain
   task automatic drain();
      while (pending_beats.size() > 0 || expected_maps.size() > 0 || start)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [CB-1:0] pick_coord(int i, bit legal);
      longint unsigned e;
      e = dim_size(i);
      if (legal) return CB'($urandom_range(0, int'(e) - 1));
      case ($urandom_range(0, 3))
         0: return '1;
         1: return '0;
         default: return CB'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic cmd_beat_type random_beat();
      cmd_beat_type b;
      longint unsigned span;
      bit legal;
      legal = $urandom_range(0, 9) < 8;
      span = 1;
      for (int i = 0; i < active_dims(); i++) span *= dim_size(i);
      b.op = 1'($urandom_range(0, 1));
      for (int i = 0; i < MAX_DIMS; i++) b.coord[i] = pick_coord(i, legal);
      if (legal) b.flat = FLAT_W'({$urandom, $urandom} % span);
      else if ($urandom_range(0, 1)) b.flat = FLAT_W'({$urandom, $urandom});
      else b.flat = FLAT_W'(span + $urandom_range(0, 3));
      return b;
   endfunction

   function automatic cmd_beat_type make_beat(logic op, int c0, int c1, int c2, int c3,
                                              longint unsigned f);
      cmd_beat_type b;
      b.op = op;
      b.coord[0] = CB'(c0); b.coord[1] = CB'(c1); b.coord[2] = CB'(c2); b.coord[3] = CB'(c3);
      b.flat = FLAT_W'(f);
      return b;
   endfunction

   // shape settings: extremes, odd sizes, out-of-range register codes
   task automatic set_shape(int dims, int e0, int e1, int e2, int e3);
      write_reg(CSR_NUM_DIMS, (CB+1)'(dims));
      write_reg(CSR_EXTENT_0, (CB+1)'(e0));
      write_reg(CSR_EXTENT_1, (CB+1)'(e1));
      write_reg(CSR_EXTENT_2, (CB+1)'(e2));
      write_reg(CSR_EXTENT_3, (CB+1)'(e3));
      csr_valid <= 1'b0;
   endtask

   initial begin
      shadow_dims = 1;
      for (int i = 0; i < MAX_DIMS; i++) shadow_extent[i] = 1024;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset shape first
      pending_beats.push_back(make_beat(OP_TO_FLAT, 1023, 1023, 1023, 1023, 0));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 64'hFF_FFFF_FFFF));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 1023));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 1024));
      drain();
      set_shape(4, 1024, 1024, 1024, 1024);
      pending_beats.push_back(make_beat(OP_TO_FLAT, 1023, 1023, 1023, 1023, 0));
      pending_beats.push_back(make_beat(OP_TO_FLAT, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 64'hFF_FFFF_FFFF));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 0));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 64'h55_5555_5555));
      drain();
      // zero dims and zero/oversized extents
      set_shape(0, 0, 2047, 0, 0);
      pending_beats.push_back(make_beat(OP_TO_FLAT, 1, 5, 5, 5, 0));
      pending_beats.push_back(make_beat(OP_TO_FLAT, 0, 1023, 1023, 1023, 0));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 1));
      drain();
      set_shape(7, 3, 1, 2047, 5);
      pending_beats.push_back(make_beat(OP_TO_FLAT, 2, 0, 1023, 4, 0));
      pending_beats.push_back(make_beat(OP_TO_FLAT, 3, 1, 0, 5, 0));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 3 * 1024 * 5 - 1));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 3 * 1024 * 5));
      pending_beats.push_back(make_beat(OP_TO_COORD, 0, 0, 0, 0, 64'hAA_AAAA_AAAA));
      drain();

      // random phases over random and fixed shapes, last phase without idling
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 11) idle_enabled = 1'b0;
         case (ph % 4)
            0: set_shape($urandom_range(1, 4), $urandom_range(1, 1024), $urandom_range(1, 1024),
                         $urandom_range(1, 1024), $urandom_range(1, 1024));
            1: set_shape($urandom_range(0, 7), $urandom_range(1, 8), $urandom_range(1, 8),
                         $urandom_range(1, 8), $urandom_range(1, 8));
            2: set_shape(4, 1024, 1024, 1024, 1024);
            default: set_shape(2, 1, $urandom_range(1, 1024), $urandom_range(0, 2047), 1);
         endcase
         for (int n = 0; n < 128; n++) begin
            pending_beats.push_back(random_beat());
            // sender holds back once until everything has come out
            if (ph == 5 && n == 60) begin
               while (pending_beats.size() > 1 || expected_maps.size() > 0 || start)
                  @(posedge clock);
               hold_off = 1'b1;
               repeat (LATENCY) @(posedge clock);
               hold_off = 1'b0;
            end
            if ($urandom_range(0, 3) == 0) @(posedge clock);
         end
         drain();
      end

      if (mismatch_count == 0 && expected_maps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(4_000_000ns);
      $display("FAILURE");
      $finish;
   end
endmodule

FILE: sim.f
src/gim_pkg.sv
src/gim_lane.sv
src/gim_merge.sv
src/grid_index_mapper_unit.sv
bench/tb_grid_index_mapper_unit.sv
